[rtl/ssag_pkg.sv]
// ============================================================================
// ssag_pkg
// Shared types and constants of the spiral scan address generator.
// ============================================================================
`default_nettype none

package ssag_pkg;

    // Configuration register layout
    localparam int CFG_W      = 7;   // width of the rows / cols registers
    localparam int CFG_ADDR_W = 1;   // register index width

    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS = 1'd1;

    // Result field widths
    localparam int OUT_W = 6;        // row and col address fields

    // Stream data widths (byte aligned)
    localparam int S_DATA_W = 8;     // restart
    localparam int M_DATA_W = 16;    // row, col

    // Side of the current ring being walked
    typedef enum logic [1:0] {
        LEG_DOWN  = 2'd0,
        LEG_RIGHT = 2'd1,
        LEG_UP    = 2'd2,
        LEG_LEFT  = 2'd3
    } leg_t;

endpackage : ssag_pkg

`default_nettype wire

[rtl/ssag_step.sv]
// ============================================================================
// ssag_step
// One step of the spiral walk: from the current address, ring and leg, works
// out the next address, or flags that the scan has run out of rings.
// ============================================================================
`default_nettype none

module ssag_step #(
    parameter int MAX_DIM = 64
) (
    input  wire logic [$clog2(MAX_DIM+1)-1:0] eff_rows,
    input  wire logic [$clog2(MAX_DIM+1)-1:0] eff_cols,
    input  wire logic [$clog2(MAX_DIM)-1:0]   cur_row,
    input  wire logic [$clog2(MAX_DIM)-1:0]   cur_col,
    input  wire logic [$clog2(MAX_DIM)-1:0]   ring,
    input  wire ssag_pkg::leg_t                leg,
    output logic      [$clog2(MAX_DIM)-1:0]   nxt_row,
    output logic      [$clog2(MAX_DIM)-1:0]   nxt_col,
    output logic      [$clog2(MAX_DIM)-1:0]   nxt_ring,
    output ssag_pkg::leg_t                     nxt_leg,
    output logic                               scan_end
);
    import ssag_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM+1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int SW    = DIM_W + 2;

    logic signed [SW-1:0] er_s;
    logic signed [SW-1:0] ec_s;
    logic signed [SW-1:0] r_s;
    logic signed [SW-1:0] y_s;
    logic signed [SW-1:0] x_s;
    logic signed [SW-1:0] h_s;
    logic signed [SW-1:0] l_s;
    logic signed [SW-1:0] y_max;
    logic signed [SW-1:0] x_max;
    logic                 ring_last;   // next ring would be empty
    logic [IDX_W-1:0]     ring_inc;

    // Ring geometry
    assign er_s      = SW'(eff_rows);
    assign ec_s      = SW'(eff_cols);
    assign r_s       = SW'(ring);
    assign y_s       = SW'(cur_row);
    assign x_s       = SW'(cur_col);
    assign h_s       = er_s - (r_s <<< 1);
    assign l_s       = ec_s - (r_s <<< 1);
    assign y_max     = er_s - r_s - SW'(1);
    assign x_max     = ec_s - r_s - SW'(1);
    assign ring_last = (h_s <= SW'(2)) || (l_s <= SW'(2));
    assign ring_inc  = ring + IDX_W'(1);

    // Next address
    always_comb
    begin
        nxt_row  = cur_row;
        nxt_col  = cur_col;
        nxt_ring = ring;
        nxt_leg  = leg;
        scan_end = 1'b0;

        if ((h_s <= SW'(0)) || (l_s <= SW'(0)))
        begin
            scan_end = 1'b1;
        end
        else if (h_s == SW'(1))
        begin
            // single-row ring: left to right
            if (x_s < x_max)
            begin
                nxt_col = cur_col + IDX_W'(1);
            end
            else
            begin
                scan_end = 1'b1;
            end
        end
        else if (l_s == SW'(1))
        begin
            // single-column ring: top to bottom
            if (y_s < y_max)
            begin
                nxt_row = cur_row + IDX_W'(1);
            end
            else
            begin
                scan_end = 1'b1;
            end
        end
        else
        begin
            unique case (leg)
                LEG_DOWN:
                begin
                    if (y_s < y_max)
                    begin
                        nxt_row = cur_row + IDX_W'(1);
                    end
                    else
                    begin
                        nxt_leg = LEG_RIGHT;
                        nxt_col = cur_col + IDX_W'(1);
                    end
                end
                LEG_RIGHT:
                begin
                    if (x_s < x_max)
                    begin
                        nxt_col = cur_col + IDX_W'(1);
                    end
                    else
                    begin
                        nxt_leg = LEG_UP;
                        nxt_row = cur_row - IDX_W'(1);
                    end
                end
                LEG_UP:
                begin
                    if (y_s > r_s)
                    begin
                        nxt_row = cur_row - IDX_W'(1);
                    end
                    else if (l_s >= SW'(3))
                    begin
                        nxt_leg = LEG_LEFT;
                        nxt_col = cur_col - IDX_W'(1);
                    end
                    else
                    begin
                        scan_end = ring_last;
                        nxt_ring = ring_inc;
                        nxt_row  = ring_inc;
                        nxt_col  = ring_inc;
                        nxt_leg  = LEG_DOWN;
                    end
                end
                default:
                begin
                    if (x_s > r_s + SW'(1))
                    begin
                        nxt_col = cur_col - IDX_W'(1);
                    end
                    else
                    begin
                        scan_end = ring_last;
                        nxt_ring = ring_inc;
                        nxt_row  = ring_inc;
                        nxt_col  = ring_inc;
                        nxt_leg  = LEG_DOWN;
                    end
                end
            endcase
        end
    end

endmodule : ssag_step

`default_nettype wire

[rtl/spiral_scan_address_generator_top.sv]
// ============================================================================
// spiral_scan_address_generator_top
// Emits the (row, col) addresses of a rows-by-cols matrix in spiral order,
// one address per request, flagging the final address of each scan.
// ============================================================================
//
//  Channel | Signals                          | Contents
//  --------+----------------------------------+----------------------------------
//  s_*     | s_tvalid s_tready s_tdata[7:0]   | [0] restart
//  m_*     | m_tvalid m_tready m_tdata[15:0]  | [5:0] row, [11:6] col
//          | m_tlast                          | last_of_scan
//  cfg_*   | cfg_we cfg_addr cfg_wdata[6:0]   | 0 rows, 1 cols
//
//  One request per cycle unless the output stalls; each address is registered
//  in the output register while the step logic updates the scan state registers.
//  The output register frees as it is taken, so a request is accepted in the
//  same cycle that the previous address leaves.
//  Reset clears the scan state; rows and cols come up as 64 (or MAX_DIM).
//  A configuration write abandons the active scan.
// ============================================================================
`default_nettype none

module spiral_scan_address_generator_top #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ssag_pkg::S_DATA_W-1:0]    s_tdata,   // [0] restart
    // address stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ssag_pkg::M_DATA_W-1:0]    m_tdata,   // [5:0] row, [11:6] col
    output logic                                   m_tlast,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [ssag_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [ssag_pkg::CFG_W-1:0]       cfg_wdata
);
    import ssag_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM+1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int REM_W = $clog2(MAX_DIM*MAX_DIM+1);
    localparam int RST_DIM = (MAX_DIM < 64) ? MAX_DIM : 64;

    // Clamp a dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            if (v == '0)
                d = DIM_W'(1);
            else if (32'(v) > MAX_DIM)
                d = DIM_W'(MAX_DIM);
            else
                d = DIM_W'(v);
            return d;
        end
    endfunction

    // Configuration and scan state
    logic [DIM_W-1:0] eff_rows_reg, eff_rows_next;
    logic [DIM_W-1:0] eff_cols_reg, eff_cols_next;
    logic [REM_W-1:0] total_reg,    total_next;
    logic [IDX_W-1:0] cur_row_reg,  cur_row_next;
    logic [IDX_W-1:0] cur_col_reg,  cur_col_next;
    logic [IDX_W-1:0] ring_reg,     ring_next;
    leg_t             leg_reg,      leg_next;
    logic [REM_W-1:0] remaining_reg, remaining_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_row_reg,   out_row_next;
    logic [OUT_W-1:0] out_col_reg,   out_col_next;
    logic             out_last_reg,  out_last_next;

    // Step datapath
    logic             accept;
    logic             start;
    logic [IDX_W-1:0] st_row;
    logic [IDX_W-1:0] st_col;
    logic [IDX_W-1:0] st_ring;
    leg_t             st_leg;
    logic [REM_W-1:0] rem_dec;
    logic             is_last;
    logic [IDX_W-1:0] adv_row;
    logic [IDX_W-1:0] adv_col;
    logic [IDX_W-1:0] adv_ring;
    leg_t             adv_leg;
    logic             adv_end;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Restart or idle: begin a new scan at the top-left corner
    assign start   = s_tdata[0] || (remaining_reg == '0);
    assign st_row  = start ? '0 : cur_row_reg;
    assign st_col  = start ? '0 : cur_col_reg;
    assign st_ring = start ? '0 : ring_reg;
    assign st_leg  = start ? LEG_DOWN : leg_reg;
    assign rem_dec = (start ? total_reg : remaining_reg) - REM_W'(1);
    assign is_last = (rem_dec == '0);

    ssag_step #(
        .MAX_DIM (MAX_DIM)
    ) u_step (
        .eff_rows (eff_rows_reg),
        .eff_cols (eff_cols_reg),
        .cur_row  (st_row),
        .cur_col  (st_col),
        .ring     (st_ring),
        .leg      (st_leg),
        .nxt_row  (adv_row),
        .nxt_col  (adv_col),
        .nxt_ring (adv_ring),
        .nxt_leg  (adv_leg),
        .scan_end (adv_end)
    );

    // Next state
    always_comb
    begin
        eff_rows_next  = eff_rows_reg;
        eff_cols_next  = eff_cols_reg;
        total_next     = total_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        ring_next      = ring_reg;
        leg_next       = leg_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_row_next   = OUT_W'(st_row);
            out_col_next   = OUT_W'(st_col);
            out_last_next  = is_last;
            if (is_last || adv_end)
            begin
                remaining_next = '0;
                cur_row_next   = '0;
                cur_col_next   = '0;
                ring_next      = '0;
                leg_next       = LEG_DOWN;
            end
            else
            begin
                remaining_next = rem_dec;
                cur_row_next   = adv_row;
                cur_col_next   = adv_col;
                ring_next      = adv_ring;
                leg_next       = adv_leg;
            end
        end

        // The user must write registers only while idle; the block does not enforce this. A write drops any scan
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ROWS:
                begin
                    eff_rows_next = eff_dim(cfg_wdata);
                    total_next    = REM_W'(eff_rows_next) * REM_W'(eff_cols_reg);
                end
                CFG_COLS:
                begin
                    eff_cols_next = eff_dim(cfg_wdata);
                    total_next    = REM_W'(eff_rows_reg) * REM_W'(eff_cols_next);
                end
                default:
                begin
                    eff_rows_next = eff_rows_reg;
                end
            endcase
            remaining_next = '0;
            cur_row_next   = '0;
            cur_col_next   = '0;
            ring_next      = '0;
            leg_next       = LEG_DOWN;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_rows_reg  <= DIM_W'(RST_DIM);
            eff_cols_reg  <= DIM_W'(RST_DIM);
            total_reg     <= REM_W'(RST_DIM * RST_DIM);
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            ring_reg      <= '0;
            leg_reg       <= LEG_DOWN;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eff_rows_reg  <= eff_rows_next;
            eff_cols_reg  <= eff_cols_next;
            total_reg     <= total_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            ring_reg      <= ring_next;
            leg_reg       <= leg_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - 2*OUT_W)'(0), out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

endmodule : spiral_scan_address_generator_top

`default_nettype wire

[tb/spiral_scan_address_generator_top_test.sv]
// ============================================================================
// spiral_scan_address_generator_top_test
// Checks the spiral scan address generator against a cycle-free model of the
// spiral walk. Each accepted request is stepped through the model, and every
// address that leaves the block is compared with the oldest predicted one.
// Directed sizes cover thin rings, 1x1, square and clamped dimensions.
// Random scans then run under sender and receiver idling and a long output stall.
// ============================================================================
`timescale 1ns / 1ps

module spiral_scan_address_generator_top_test;

    import ssag_pkg::*;

    localparam int MAX_DIM     = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam int REPORT_MAX  = 10;

    // One predicted address
    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             last;
    } spiral_addr_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // [0] restart
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // [5:0] row, [11:6] col
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // Spiral model state
    logic [CFG_W-1:0] scan_rows;
    logic [CFG_W-1:0] scan_cols;
    int               pos_row;
    int               pos_col;
    leg_t             cur_leg;
    int               ring_idx;
    int               left_count;

    spiral_addr_t     addr_queue[$];
    spiral_addr_t     want_addr;

    // Run control and bookkeeping
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_off     = 1'b0;
    int  cycle_count   = 0;
    int  mismatch_count = 0;
    int  requests_sent  = 0;
    int  results_seen   = 0;
    int  scans_done     = 0;
    int  settings_used  = 0;

    spiral_scan_address_generator_top #(
        .MAX_DIM (MAX_DIM)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Spiral model
    // ------------------------------------------------------------------------

    // Out-of-range sizes: 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic int clamp_dim(input logic [CFG_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void clear_scan();
        left_count = 0;
        pos_row    = 0;
        pos_col    = 0;
        ring_idx   = 0;
        cur_leg    = LEG_DOWN;
    endfunction

    // Step inward; the scan ends when the inner ring would be empty
    function automatic void enter_next_ring(input int h, input int l);
        ring_idx++;
        if (h - 2 <= 0 || l - 2 <= 0)
        begin
            clear_scan();
        end
        else
        begin
            pos_row = ring_idx;
            pos_col = ring_idx;
        end
        cur_leg = LEG_DOWN;
    endfunction

    function automatic void walk_spiral();
        int r;
        int h;
        int l;
        r = ring_idx;
        h = clamp_dim(scan_rows) - 2 * r;
        l = clamp_dim(scan_cols) - 2 * r;
        if (h <= 0 || l <= 0)
        begin
            clear_scan();
        end
        // single row ring runs left to right
        else if (h == 1)
        begin
            if (pos_col < r + l - 1)
                pos_col++;
            else
                enter_next_ring(h, l);
        end
        // single column ring runs top to bottom
        else if (l == 1)
        begin
            if (pos_row < r + h - 1)
                pos_row++;
            else
                enter_next_ring(h, l);
        end
        else
        begin
            case (cur_leg)
                LEG_DOWN:
                begin
                    if (pos_row < r + h - 1)
                        pos_row++;
                    else
                    begin
                        cur_leg = LEG_RIGHT;
                        pos_col++;
                    end
                end
                LEG_RIGHT:
                begin
                    if (pos_col < r + l - 1)
                        pos_col++;
                    else
                    begin
                        cur_leg = LEG_UP;
                        pos_row--;
                    end
                end
                LEG_UP:
                begin
                    if (pos_row > r)
                        pos_row--;
                    else if (l >= 3)
                    begin
                        cur_leg = LEG_LEFT;
                        pos_col--;
                    end
                    else
                        enter_next_ring(h, l);
                end
                default:
                begin
                    // top row leaves out both corners
                    if (pos_col > r + 1)
                        pos_col--;
                    else
                        enter_next_ring(h, l);
                end
            endcase
        end
    endfunction

    // Predict the address caused by one accepted request
    function automatic void predict_address(input logic restart);
        spiral_addr_t a;
        if (restart || left_count == 0)
        begin
            clear_scan();
            left_count = clamp_dim(scan_rows) * clamp_dim(scan_cols);
        end
        a.row = pos_row[OUT_W-1:0];
        a.col = pos_col[OUT_W-1:0];
        left_count--;
        a.last = (left_count == 0);
        if (left_count != 0)
            walk_spiral();
        else
            clear_scan();
        addr_queue.push_back(a);
    endfunction

    // Any register write abandons the active scan
    function automatic void apply_config(input logic [CFG_ADDR_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        if (idx == CFG_ROWS)
            scan_rows = val;
        else if (idx == CFG_COLS)
            scan_cols = val;
        clear_scan();
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side, result checker, cycle limit
    // ------------------------------------------------------------------------

    // Random ready; forced low during a hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each address leaving the block with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (addr_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected address: row %0d col %0d last %0b",
                             m_tdata[5:0], m_tdata[11:6], m_tlast);
            end
            else
            begin
                want_addr = addr_queue.pop_front();
                if (m_tdata[5:0] !== want_addr.row || m_tdata[11:6] !== want_addr.col
                    || m_tlast !== want_addr.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: expected %0d,%0d last %0b, got %0d,%0d last %0b",
                                 want_addr.row, want_addr.col, want_addr.last,
                                 m_tdata[5:0], m_tdata[11:6], m_tlast);
                end
                if (want_addr.last)
                    scans_done++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d addresses pending",
                     cycle_count, addr_queue.size());
            $display("spiral_scan_address_generator_top_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(input logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, restart};
        do
            @(posedge clk);
        while (!s_tready);
        predict_address(restart);
        requests_sent++;
    endtask

    // Write a register once all outstanding addresses have arrived
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (addr_queue.size() != 0 || m_tvalid)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        apply_config(idx, val);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
        write_reg(CFG_ROWS, r);
        write_reg(CFG_COLS, c);
        settings_used++;
    endtask

    task automatic send_run(input int n, input int restart_pct);
        for (int i = 0; i < n; i++)
            send_request($urandom_range(99) < restart_pct);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Sizes come up as 64x64: first addresses walk down the left column
    task automatic test_reset_sizes();
        send_run(3, 0);
    endtask

    // One-row ring runs right, one-column ring runs down
    task automatic test_thin_rings();
        set_size(7'd1, 7'd3);
        send_run(3, 0);
        set_size(7'd3, 7'd1);
        send_run(3, 0);
    endtask

    // Zero sizes act as 1x1; 2x2 with a restart mid-scan; 3x3 reaches the center
    task automatic test_small_squares();
        set_size(7'd0, 7'd0);
        send_run(2, 0);
        set_size(7'd2, 7'd2);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        set_size(7'd3, 7'd3);
        send_run(9, 0);
    endtask

    // Clamped and full-range sizes reach every address bit
    task automatic test_extreme_sizes();
        set_size(7'd127, 7'd0);
        send_run(64, 0);
        set_size(7'd0, 7'd64);
        send_run(64, 0);
        set_size(7'd64, 7'd127);
        send_run(30, 0);
        send_run(6, 50);
        // cols register alone, written mid-scan
        write_reg(CFG_COLS, 7'd2);
        settings_used++;
        send_run(130, 0);
    endtask

    // Random sizes, mostly whole scans, some abandoned and some restarted
    task automatic test_random_scans(input int n_items);
        int sent;
        int prod;
        int k;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(19))
                0:
                begin
                    r = CFG_W'($urandom_range(10, 127));
                    c = CFG_W'($urandom_range(0, 127));
                end
                1, 2:
                begin
                    r = CFG_W'($urandom_range(10, 127));
                    c = CFG_W'($urandom_range(0, 3));
                end
                3, 4:
                begin
                    r = CFG_W'($urandom_range(0, 3));
                    c = CFG_W'($urandom_range(10, 127));
                end
                default:
                begin
                    r = CFG_W'($urandom_range(0, 9));
                    c = CFG_W'($urandom_range(0, 9));
                end
            endcase
            if ($urandom_range(3) == 0)
            begin
                write_reg($urandom_range(1) ? CFG_ROWS : CFG_COLS, r);
                settings_used++;
            end
            else
                set_size(r, c);
            prod = clamp_dim(scan_rows) * clamp_dim(scan_cols);
            k = prod + $urandom_range(0, 2);
            if ($urandom_range(9) == 0)
                k = $urandom_range(1, prod);
            if (k > 160)
                k = 160;
            if (k > n_items - sent)
                k = n_items - sent;
            send_run(k, 4);
            sent += k;
        end
        s_tvalid <= 1'b0;
    endtask

    // Output held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_size(7'd5, 7'd6);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        send_run(40, 0);
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        scan_rows = 7'd64;
        scan_cols = 7'd64;
        clear_scan();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_thin_rings();
        test_small_squares();
        test_extreme_sizes();

        send_idle_pct = 14;
        recv_idle_pct = 76;
        test_random_scans(530);

        send_idle_pct = 76;
        recv_idle_pct = 14;
        test_random_scans(530);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_scans(530);

        // drain, then allow for the output register
        s_tvalid <= 1'b0;
        while (addr_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests over %0d size settings, %0d complete scans",
                 requests_sent, settings_used, scans_done);
        $display("checked %0d addresses, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0 && addr_queue.size() == 0)
            $display("spiral_scan_address_generator_top_test OK");
        else
            $display("spiral_scan_address_generator_top_test NOT OK");
        $finish;
    end

endmodule
